// File: hdl/rgb_clear_normalize_classify_assert.svh
// Assertion macros for the color normalizer checker.
`ifndef RGB_CLEAR_NORMALIZE_CLASSIFY_ASSERT_SVH
`define RGB_CLEAR_NORMALIZE_CLASSIFY_ASSERT_SVH

// ante implies cons in the same cycle
`define RGBCN_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbcn assertion failed");

// ante implies cons a fixed number of cycles later
`define RGBCN_ASSERT_DELAY(label, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("rgbcn delayed assertion failed");

`endif

// File: hdl/rgbcn_pkg.sv
// Types, constants and the divider step for the color normalizer.
package rgbcn_pkg;

    localparam int NUM_CH          = 3;
    localparam int DIV_STAGES      = 4;
    localparam int STEPS_PER_STAGE = 2;
    localparam int LATENCY         = DIV_STAGES + 2;

    localparam logic [7:0] LEVEL_MAX = 8'd255;

    localparam logic [15:0] MIN_RAW_RESET      = 16'd0;
    localparam logic [15:0] BLUE_MIN_RAW_RESET = 16'd2;

    localparam logic REG_MIN_RAW      = 1'b0;
    localparam logic REG_BLUE_MIN_RAW = 1'b1;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef enum logic [1:0] {
        CLASS_NONE  = 2'd0,
        CLASS_RED   = 2'd1,
        CLASS_GREEN = 2'd2,
        CLASS_BLUE  = 2'd3
    } color_class_t;

    // partial remainder, dividend bits not yet shifted in, quotient so far
    typedef struct packed {
        logic [15:0] rem;
        logic [7:0]  low;
        logic [7:0]  quo;
    } div_lane_t;

    // one restoring division step
    function automatic div_lane_t div_step(div_lane_t cur, logic [15:0] divisor);
        div_lane_t   nxt;
        logic [16:0] trial;
        logic [16:0] diff;
        trial = {cur.rem, cur.low[7]};
        diff = trial - {1'b0, divisor};
        nxt.low = {cur.low[6:0], 1'b0};
        if (trial >= {1'b0, divisor})
        begin
            nxt.rem = diff[15:0];
            nxt.quo = {cur.quo[6:0], 1'b1};
        end
        else
        begin
            nxt.rem = trial[15:0];
            nxt.quo = {cur.quo[6:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

// File: hdl/rgb_clear_normalize_classify.sv
// Color reading normalizer and classifier, pipelined top level.
// Results strobe on done after the input register, the four divider stage registers and the output register.
// Throughput: one reading per cycle; busy is always low, results cannot be held off.
// Depth is set by the 8-bit quotient, two restoring steps in each of four stages.
// Reset clears the pipeline valid bits and loads the threshold registers.
module rgb_clear_normalize_classify (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] red_raw,
    input  logic [15:0] green_raw,
    input  logic [15:0] blue_raw,
    input  logic [15:0] clear_raw,
    output logic        done,
    output logic [7:0]  red_level,
    output logic [7:0]  green_level,
    output logic [7:0]  blue_level,
    output logic [1:0]  color_class,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rgbcn_pkg::*;

    logic [15:0] min_raw_reg;
    logic [15:0] blue_min_raw_reg;

    logic                valid_reg   [0:DIV_STAGES];
    logic [15:0]         divisor_reg [0:DIV_STAGES];
    logic                zero_reg    [0:DIV_STAGES];
    logic [NUM_CH-1:0]   sat_reg     [0:DIV_STAGES];
    logic [NUM_CH-1:0]   pass_reg    [0:DIV_STAGES];
    div_lane_t           lane_reg    [0:DIV_STAGES][0:NUM_CH-1];
    div_lane_t           lane_next   [1:DIV_STAGES][0:NUM_CH-1];

    logic [15:0]         raw_in [0:NUM_CH-1];
    div_lane_t           lane_in [0:NUM_CH-1];
    logic [NUM_CH-1:0]   sat_in;
    logic [NUM_CH-1:0]   pass_in;

    logic                done_reg;
    logic [7:0]          level_reg [0:NUM_CH-1];
    logic [7:0]          level_next [0:NUM_CH-1];
    color_class_t        class_reg;
    color_class_t        class_next;

    logic accept;
    logic cfg_write;

    assign busy      = 1'b0;
    assign pready    = 1'b1;
    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_raw_reg      <= MIN_RAW_RESET;
            blue_min_raw_reg <= BLUE_MIN_RAW_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_MIN_RAW:      min_raw_reg      <= pwdata[15:0];
                REG_BLUE_MIN_RAW: blue_min_raw_reg <= pwdata[15:0];
                default:          min_raw_reg      <= min_raw_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_MIN_RAW:      prdata = {16'd0, min_raw_reg};
            REG_BLUE_MIN_RAW: prdata = {16'd0, blue_min_raw_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // input stage: dividend raw*255, saturation and threshold tests
    assign raw_in[CH_RED]   = red_raw;
    assign raw_in[CH_GREEN] = green_raw;
    assign raw_in[CH_BLUE]  = blue_raw;

    always_comb
    begin
        logic [23:0] prod;
        for (int c = 0; c < NUM_CH; c++)
        begin
            prod = {raw_in[c], 8'd0} - {8'd0, raw_in[c]};
            lane_in[c].rem = prod[23:8];
            lane_in[c].low = prod[7:0];
            lane_in[c].quo = 8'd0;
            sat_in[c] = (raw_in[c] >= clear_raw);
        end
        pass_in[CH_RED]   = (red_raw > min_raw_reg);
        pass_in[CH_GREEN] = (green_raw > min_raw_reg);
        pass_in[CH_BLUE]  = (blue_raw > blue_min_raw_reg);
    end

    // divider stages
    always_comb
    begin
        div_lane_t tmp;
        for (int k = 1; k <= DIV_STAGES; k++)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                tmp = lane_reg[k-1][c];
                for (int s = 0; s < STEPS_PER_STAGE; s++)
                begin
                    tmp = div_step(tmp, divisor_reg[k-1]);
                end
                lane_next[k][c] = tmp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= accept;
            for (int k = 1; k <= DIV_STAGES; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
            done_reg <= valid_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            divisor_reg[0] <= clear_raw;
            zero_reg[0]    <= (clear_raw == 16'd0);
            sat_reg[0]     <= sat_in;
            pass_reg[0]    <= pass_in;
            for (int c = 0; c < NUM_CH; c++)
            begin
                lane_reg[0][c] <= lane_in[c];
            end
        end
        for (int k = 1; k <= DIV_STAGES; k++)
        begin
            if (valid_reg[k-1])
            begin
                divisor_reg[k] <= divisor_reg[k-1];
                zero_reg[k]    <= zero_reg[k-1];
                sat_reg[k]     <= sat_reg[k-1];
                pass_reg[k]    <= pass_reg[k-1];
                for (int c = 0; c < NUM_CH; c++)
                begin
                    lane_reg[k][c] <= lane_next[k][c];
                end
            end
        end
        if (valid_reg[DIV_STAGES])
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                level_reg[c] <= level_next[c];
            end
            class_reg <= class_next;
        end
    end

    // final levels and classification
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (zero_reg[DIV_STAGES])
            begin
                level_next[c] = 8'd0;
            end
            else if (sat_reg[DIV_STAGES][c])
            begin
                level_next[c] = LEVEL_MAX;
            end
            else
            begin
                level_next[c] = lane_reg[DIV_STAGES][c].quo;
            end
        end
        if (level_next[CH_RED] > level_next[CH_GREEN] &&
            level_next[CH_RED] > level_next[CH_BLUE] && pass_reg[DIV_STAGES][CH_RED])
        begin
            class_next = CLASS_RED;
        end
        else if (level_next[CH_GREEN] > level_next[CH_RED] &&
                 level_next[CH_GREEN] > level_next[CH_BLUE] &&
                 pass_reg[DIV_STAGES][CH_GREEN])
        begin
            class_next = CLASS_GREEN;
        end
        else if (level_next[CH_BLUE] > level_next[CH_RED] &&
                 level_next[CH_BLUE] > level_next[CH_GREEN] &&
                 pass_reg[DIV_STAGES][CH_BLUE])
        begin
            class_next = CLASS_BLUE;
        end
        else
        begin
            class_next = CLASS_NONE;
        end
    end

    assign done        = done_reg;
    assign red_level   = level_reg[CH_RED];
    assign green_level = level_reg[CH_GREEN];
    assign blue_level  = level_reg[CH_BLUE];
    assign color_class = class_reg;

endmodule

// File: hdl/rgbcn_checker.sv
// Port-level checker for the color normalizer, bound to the top level.
`include "rgb_clear_normalize_classify_assert.svh"

module rgbcn_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [7:0]  red_level,
    input logic [7:0]  green_level,
    input logic [7:0]  blue_level,
    input logic [1:0]  color_class
);
    import rgbcn_pkg::*;

    logic red_top;
    logic green_top;
    logic blue_top;

    assign red_top   = (red_level > green_level) && (red_level > blue_level);
    assign green_top = (green_level > red_level) && (green_level > blue_level);
    assign blue_top  = (blue_level > red_level) && (blue_level > green_level);

    `RGBCN_ASSERT_DELAY(a_beat_returns, start && !busy, 6, done)
    `RGBCN_ASSERT_IMPL(a_red_dominant, done && color_class == CLASS_RED, red_top)
    `RGBCN_ASSERT_IMPL(a_green_dominant, done && color_class == CLASS_GREEN, green_top)
    `RGBCN_ASSERT_IMPL(a_blue_dominant, done && color_class == CLASS_BLUE, blue_top)

endmodule

bind rgb_clear_normalize_classify rgbcn_checker u_rgbcn_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .red_level   (red_level),
    .green_level (green_level),
    .blue_level  (blue_level),
    .color_class (color_class)
);

// File: tb/sv/tb_rgb_clear_normalize_classify.sv
// Self-checking testbench for the color reading normalizer and classifier.
module tb_rgb_clear_normalize_classify;
    import rgbcn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] clear;
    } reading_t;

    typedef struct {
        logic [7:0]   red;
        logic [7:0]   green;
        logic [7:0]   blue;
        color_class_t cls;
    } color_result_t;

    typedef struct {
        reading_t      rd;
        bit            typed;
        color_result_t want;
    } directed_row_t;

    localparam logic [2:0] ADDR_MIN_RAW      = {REG_MIN_RAW, 2'b00};
    localparam logic [2:0] ADDR_BLUE_MIN_RAW = {REG_BLUE_MIN_RAW, 2'b00};
    localparam int NUM_PHASES = 7;
    localparam int PHASE_BEATS = 250;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] red_raw = '0;
    logic [15:0] green_raw = '0;
    logic [15:0] blue_raw = '0;
    logic [15:0] clear_raw = '0;
    logic        done;
    logic [7:0]  red_level;
    logic [7:0]  green_level;
    logic [7:0]  blue_level;
    logic [1:0]  color_class;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [15:0] min_level = MIN_RAW_RESET;
    logic [15:0] blue_min_level = BLUE_MIN_RAW_RESET;

    color_result_t pending_colors[$];
    color_result_t typed_colors[$];
    bit            typed_valid[$];
    int            mismatch_count = 0;

    rgb_clear_normalize_classify dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .red_raw(red_raw),
        .green_raw(green_raw),
        .blue_raw(blue_raw),
        .clear_raw(clear_raw),
        .done(done),
        .red_level(red_level),
        .green_level(green_level),
        .blue_level(blue_level),
        .color_class(color_class),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] scaled_level(logic [15:0] raw, logic [15:0] clear);
        logic [31:0] q;
        if (clear == 16'd0)
            return 8'd0;
        q = ({16'd0, raw} * 32'd255) / {16'd0, clear};
        return (q > 32'd255) ? LEVEL_MAX : q[7:0];
    endfunction

    function automatic color_result_t predict_color(reading_t rd);
        color_result_t res;
        res.red = scaled_level(rd.red, rd.clear);
        res.green = scaled_level(rd.green, rd.clear);
        res.blue = scaled_level(rd.blue, rd.clear);
        res.cls = CLASS_NONE;
        if (res.red > res.green && res.red > res.blue && rd.red > min_level)
            res.cls = CLASS_RED;
        else if (res.green > res.red && res.green > res.blue && rd.green > min_level)
            res.cls = CLASS_GREEN;
        else if (res.blue > res.red && res.blue > res.green && rd.blue > blue_min_level)
            res.cls = CLASS_BLUE;
        return res;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // capture accepted beats and check results, all on pre-edge values
    always @(posedge clk)
    begin
        color_result_t got;
        color_result_t want;
        reading_t      rd;
        if (rst_n)
        begin
            if (done)
            begin
                got.red = red_level;
                got.green = green_level;
                got.blue = blue_level;
                got.cls = color_class_t'(color_class);
                if (pending_colors.size() == 0)
                begin
                    $error("result beat with no reading outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_colors.pop_front();
                    check_field("red_level", want.red, got.red);
                    check_field("green_level", want.green, got.green);
                    check_field("blue_level", want.blue, got.blue);
                    check_field("color_class", want.cls, got.cls);
                end
            end
            if (start && !busy)
            begin
                rd.red = red_raw;
                rd.green = green_raw;
                rd.blue = blue_raw;
                rd.clear = clear_raw;
                want = predict_color(rd);
                if (typed_valid.size() != 0)
                begin
                    if (typed_valid.pop_front())
                        want = typed_colors.pop_front();
                end
                pending_colors.push_back(want);
            end
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [15:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == ADDR_MIN_RAW)
            min_level = value;
        else if (addr == ADDR_BLUE_MIN_RAW)
            blue_min_level = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read_check(logic [2:0] addr, logic [15:0] want);
        psel <= 1'b1;
        pwrite <= 1'b0;
        penable <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        check_field(addr == ADDR_MIN_RAW ? "prdata min_raw_level" : "prdata blue_min_raw_level",
                    {16'd0, want}, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_thresholds(logic [15:0] red_green, logic [15:0] blue);
        apb_write(ADDR_MIN_RAW, red_green);
        apb_write(ADDR_BLUE_MIN_RAW, blue);
        apb_read_check(ADDR_MIN_RAW, red_green);
        apb_read_check(ADDR_BLUE_MIN_RAW, blue);
    endtask

    task automatic send_reading(reading_t rd);
        start <= 1'b1;
        red_raw <= rd.red;
        green_raw <= rd.green;
        blue_raw <= rd.blue;
        clear_raw <= rd.clear;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_cycles(int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n)
            begin
                red_raw <= 16'($urandom);
                green_raw <= 16'($urandom);
                blue_raw <= 16'($urandom);
                clear_raw <= 16'($urandom);
                @(posedge clk);
            end
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2)
            @(posedge clk);
    endtask

    function automatic logic [15:0] clamp16(int v);
        if (v < 0)
            return 16'd0;
        if (v > 65535)
            return 16'hffff;
        return v[15:0];
    endfunction

    function automatic reading_t random_reading();
        reading_t rd;
        int       thr;
        int       lead;
        rd.red = 16'($urandom);
        rd.green = 16'($urandom);
        rd.blue = 16'($urandom);
        rd.clear = 16'($urandom);
        case ($urandom_range(0, 7))
            0: ;
            1:
            begin
                rd.red = 16'($urandom_range(0, 15));
                rd.green = 16'($urandom_range(0, 15));
                rd.blue = 16'($urandom_range(0, 15));
                rd.clear = 16'($urandom_range(0, 15));
            end
            2: rd.clear = 16'd0;
            3:
            begin
                // one channel set to its threshold, offset by -1, 0 or +1
                lead = int'($urandom_range(CH_RED, CH_BLUE));
                thr = int'((lead == CH_BLUE) ? blue_min_level : min_level);
                thr = thr + int'($urandom_range(0, 2)) - 1;
                rd.red = 16'($urandom_range(0, clamp16(thr)));
                rd.green = 16'($urandom_range(0, clamp16(thr)));
                rd.blue = 16'($urandom_range(0, clamp16(thr)));
                if (lead == CH_RED)
                    rd.red = clamp16(thr);
                else if (lead == CH_GREEN)
                    rd.green = clamp16(thr);
                else
                    rd.blue = clamp16(thr);
                rd.clear = 16'($urandom_range(clamp16(thr), 16'hffff));
            end
            4:
            begin
                rd.green = rd.red;
                if ($urandom_range(0, 1))
                    rd.blue = rd.red;
            end
            default:
            begin
                rd.red = 16'($urandom_range(0, rd.clear));
                rd.green = 16'($urandom_range(0, rd.clear));
                rd.blue = 16'($urandom_range(0, rd.clear));
            end
        endcase
        return rd;
    endfunction

    function automatic int random_gap();
        int pick;
        pick = int'($urandom_range(0, 99));
        if (pick < 60)
            return 0;
        if (pick < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(5, 40));
    endfunction

    initial
    begin
        #2_000_000;
        $display("tb_rgb_clear_normalize_classify failed");
        $finish;
    end

    initial
    begin
        directed_row_t directed_rows[$];
        logic [15:0]   phase_min[NUM_PHASES];
        logic [15:0]   phase_blue[NUM_PHASES];
        bit            no_gaps;

        directed_rows.push_back('{'{16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
                                  '{8'd0, 8'd0, 8'd0, CLASS_NONE}});
        directed_rows.push_back('{'{16'hffff, 16'hffff, 16'hffff, 16'hffff}, 1'b1,
                                  '{8'd255, 8'd255, 8'd255, CLASS_NONE}});
        directed_rows.push_back('{'{16'hffff, 16'd0, 16'd0, 16'hffff}, 1'b1,
                                  '{8'd255, 8'd0, 8'd0, CLASS_RED}});
        directed_rows.push_back('{'{16'd0, 16'hffff, 16'd0, 16'hffff}, 1'b1,
                                  '{8'd0, 8'd255, 8'd0, CLASS_GREEN}});
        directed_rows.push_back('{'{16'd0, 16'd0, 16'hffff, 16'hffff}, 1'b1,
                                  '{8'd0, 8'd0, 8'd255, CLASS_BLUE}});
        directed_rows.push_back('{'{16'hffff, 16'h1234, 16'd7, 16'd0}, 1'b1,
                                  '{8'd0, 8'd0, 8'd0, CLASS_NONE}});
        directed_rows.push_back('{'{16'd1000, 16'd0, 16'd0, 16'd10}, 1'b1,
                                  '{8'd255, 8'd0, 8'd0, CLASS_RED}});
        directed_rows.push_back('{'{16'd500, 16'd500, 16'd3, 16'd1000}, 1'b1,
                                  '{8'd127, 8'd127, 8'd0, CLASS_NONE}});
        directed_rows.push_back('{'{16'd0, 16'd0, 16'd2, 16'd2}, 1'b1,
                                  '{8'd0, 8'd0, 8'd255, CLASS_NONE}});
        directed_rows.push_back('{'{16'd0, 16'd0, 16'd3, 16'd3}, 1'b1,
                                  '{8'd0, 8'd0, 8'd255, CLASS_BLUE}});
        directed_rows.push_back('{'{16'd1, 16'd0, 16'd0, 16'd1}, 1'b1,
                                  '{8'd255, 8'd0, 8'd0, CLASS_RED}});
        directed_rows.push_back('{'{16'd1, 16'd0, 16'd0, 16'hffff}, 1'b1,
                                  '{8'd0, 8'd0, 8'd0, CLASS_NONE}});
        directed_rows.push_back('{'{16'hffff, 16'hffff, 16'd0, 16'd1}, 1'b1,
                                  '{8'd255, 8'd255, 8'd0, CLASS_NONE}});
        directed_rows.push_back('{'{16'd0, 16'hffff, 16'hffff, 16'hffff}, 1'b1,
                                  '{8'd0, 8'd255, 8'd255, CLASS_NONE}});
        directed_rows.push_back('{'{16'd100, 16'd200, 16'd300, 16'd600}, 1'b0,
                                  '{8'd0, 8'd0, 8'd0, CLASS_NONE}});
        directed_rows.push_back('{'{16'haaaa, 16'h5555, 16'h00ff, 16'hff00}, 1'b0,
                                  '{8'd0, 8'd0, 8'd0, CLASS_NONE}});
        directed_rows.push_back('{'{16'h5555, 16'haaaa, 16'hff00, 16'h00ff}, 1'b0,
                                  '{8'd0, 8'd0, 8'd0, CLASS_NONE}});
        directed_rows.push_back('{'{16'd1, 16'd2, 16'd3, 16'h8000}, 1'b0,
                                  '{8'd0, 8'd0, 8'd0, CLASS_NONE}});

        phase_min = '{16'd0, 16'hffff, 16'd0, 16'hffff, 16'd0, 16'd0, 16'd0};
        phase_blue = '{16'd2, 16'hffff, 16'd0, 16'd0, 16'hffff, 16'd0, 16'd2};
        phase_min[4] = 16'($urandom_range(0, 15));
        phase_min[5] = 16'($urandom);
        phase_blue[5] = 16'($urandom_range(0, 15));

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_read_check(ADDR_MIN_RAW, MIN_RAW_RESET);
        apb_read_check(ADDR_BLUE_MIN_RAW, BLUE_MIN_RAW_RESET);

        foreach (directed_rows[i])
        begin
            typed_valid.push_back(directed_rows[i].typed);
            if (directed_rows[i].typed)
                typed_colors.push_back(directed_rows[i].want);
            send_reading(directed_rows[i].rd);
            idle_cycles(random_gap());
        end
        drain_results();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_thresholds(phase_min[p], phase_blue[p]);
            no_gaps = 1'b0;
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                if (n % 50 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                send_reading(random_reading());
                if ($urandom_range(0, 199) == 0)
                    drain_results();
                else if (!no_gaps)
                    idle_cycles(random_gap());
            end
            drain_results();
        end

        if (mismatch_count == 0)
            $display("tb_rgb_clear_normalize_classify passed");
        else
            $display("tb_rgb_clear_normalize_classify failed");
        $finish;
    end

endmodule
